FILE: design/epoch_seconds_to_calendar_macros.svh
// Assertion macros shared by the calendar converter modules.
`ifndef EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH
`ifndef SYNTHESIS
`define ESC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ESC_ASSERT_NEVER(lbl, cond, msg) \
  `ESC_ASSERT(lbl, !(cond), msg)
`else
`define ESC_ASSERT(lbl, prop, msg)
`define ESC_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

FILE: design/esc_pkg.sv
// Types, constants and helper functions of the epoch to calendar converter.
`timescale 1ns / 1ps
package esc_pkg;

  localparam int unsigned EpochW  = 32;
  localparam int unsigned OffsetW = 17;
  localparam int unsigned DaysW   = 16;
  localparam int unsigned DateLat = 6;

  // Reciprocals scaled by a power of two, rounded down; one correction follows
  localparam logic [30:0] Recip15   = 31'h4444_4444;  // 2^34 / 15
  localparam int unsigned Shift15   = 34;
  localparam logic [18:0] Recip3    = 19'h5_5555;     // 2^20 / 3
  localparam int unsigned Shift3    = 20;
  localparam logic [17:0] Recip7    = 18'd149796;     // 2^20 / 7
  localparam int unsigned Shift7    = 20;
  localparam logic [15:0] Recip1461 = 16'd45933;      // 2^26 / 1461
  localparam int unsigned Shift1461 = 26;

  localparam logic [11:0] DaysPerFourYears = 12'd1461;
  localparam logic [16:0] Days1900To1970   = 17'd25567;
  localparam logic [7:0]  Year2100         = 8'd200;

  typedef struct packed {
    logic [7:0]  year;
    logic [10:0] days;
  } esc_yd_t;

  typedef struct packed {
    logic [7:0] years_since_1900;
    logic [8:0] day_of_year;
    logic [3:0] month_index;
    logic [4:0] day_of_month;
    logic [2:0] weekday;
  } esc_date_t;

  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
  } esc_hms_t;

  // Year counted from 1900; 1900 and 2100 are not leap, 2000 is
  function automatic logic is_leap(input logic [7:0] y);
    return (y[1:0] == 2'b00) && (y != 8'd0) && (y != Year2100);
  endfunction

  // One pass of the year walk: drop a whole year if the days cover it
  function automatic esc_yd_t year_step(input esc_yd_t a);
    esc_yd_t    r;
    logic [10:0] ylen;
    r    = a;
    ylen = is_leap(a.year) ? 11'd366 : 11'd365;
    if (a.days >= ylen) begin
      r.days = a.days - ylen;
      r.year = a.year + 8'd1;
    end
    return r;
  endfunction

  // Zero-based day of year on which a month starts
  function automatic logic [8:0] month_start(input logic [3:0] mon, input logic leap);
    logic [8:0] s;
    unique case (mon)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd59;
      4'd3:    s = 9'd90;
      4'd4:    s = 9'd120;
      4'd5:    s = 9'd151;
      4'd6:    s = 9'd181;
      4'd7:    s = 9'd212;
      4'd8:    s = 9'd243;
      4'd9:    s = 9'd273;
      4'd10:   s = 9'd304;
      4'd11:   s = 9'd334;
      default: s = 9'd0;
    endcase
    if (leap && (mon >= 4'd2)) begin
      s = s + 9'd1;
    end
    return s;
  endfunction

endpackage

FILE: design/esc_date.sv
// Day count to weekday, year, day of year, month and day of month, six stages.
`timescale 1ns / 1ps
`include "epoch_seconds_to_calendar_macros.svh"
module esc_date
  import esc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [DaysW-1:0] days_i,
  output logic             valid_o,
  output esc_date_t        date_o
);

  // Stage 1: weekday and four-year block products
  logic        v1_q;
  logic [33:0] pw_q;
  logic [15:0] z_q;
  logic [32:0] py_q;
  logic [16:0] d_q;
  logic [15:0] z_d;
  logic [16:0] d_d;

  assign z_d = days_i + 16'd4;
  assign d_d = 17'(days_i) + Days1900To1970;

  // Stage 2: corrected weekday, block year and remainder
  logic        v2_q;
  logic [2:0]  wd2_q;
  esc_yd_t     yd2_q;
  logic [13:0] q7;
  logic [3:0]  r7;
  logic [6:0]  qy0, qy1;
  logic [11:0] ry0, ry1;
  logic [7:0]  yblk;
  esc_yd_t     yd2_d;
  logic [2:0]  wd2_d;

  always_comb begin
    q7 = pw_q[Shift7 +: 14];
    r7 = 4'(z_q[3:0] - 4'(q7[3:0] * 4'd7));
    if (r7 >= 4'd7) begin
      r7 = r7 - 4'd7;
    end
    wd2_d = r7[2:0];

    qy0 = py_q[Shift1461 +: 7];
    ry0 = 12'(d_q[11:0] - 12'(qy0 * DaysPerFourYears));
    qy1 = qy0;
    ry1 = ry0;
    if (ry0 >= DaysPerFourYears) begin
      qy1 = qy0 + 7'd1;
      ry1 = ry0 - DaysPerFourYears;
    end
    yblk        = {qy1[5:0], 2'b00};
    yd2_d.year  = yblk;
    // add back the non-leap century years inside the whole blocks
    yd2_d.days  = 11'(ry1) + 11'(yblk >= 8'd4) + 11'(yblk >= 8'd204);
  end

  // Stages 3 and 4: walk the year, two years a stage
  logic    v3_q, v4_q;
  logic [2:0] wd3_q, wd4_q;
  esc_yd_t yd3_q, yd4_q;

  // Stage 5: month search
  logic       v5_q;
  logic [2:0] wd5_q;
  logic [7:0] yr5_q;
  logic [8:0] doy5_q;
  logic       leap5_q;
  logic [3:0] mon5_q;
  logic       leap4;
  logic [8:0] doy4;
  logic [3:0] mon_d;

  always_comb begin
    leap4 = is_leap(yd4_q.year);
    doy4  = yd4_q.days[8:0];
    mon_d = 4'd0;
    for (int m = 1; m < 12; m++) begin
      mon_d = mon_d + 4'(doy4 >= month_start(4'(m), leap4));
    end
  end

  // Stage 6: day of month
  logic      v6_q;
  esc_date_t date_q;
  esc_date_t date_d;

  always_comb begin
    date_d.years_since_1900 = yr5_q;
    date_d.day_of_year      = doy5_q;
    date_d.month_index      = mon5_q;
    date_d.day_of_month     = 5'(doy5_q - month_start(mon5_q, leap5_q) + 9'd1);
    date_d.weekday          = wd5_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pw_q    <= 34'(z_d) * 34'(Recip7);
    z_q     <= z_d;
    py_q    <= 33'(d_d) * 33'(Recip1461);
    d_q     <= d_d;
    wd2_q   <= wd2_d;
    yd2_q   <= yd2_d;
    wd3_q   <= wd2_q;
    yd3_q   <= year_step(year_step(yd2_q));
    wd4_q   <= wd3_q;
    yd4_q   <= year_step(year_step(yd3_q));
    wd5_q   <= wd4_q;
    yr5_q   <= yd4_q.year;
    doy5_q  <= doy4;
    leap5_q <= leap4;
    mon5_q  <= mon_d;
    date_q  <= date_d;
  end

  assign valid_o = v6_q;
  assign date_o  = date_q;

  `ESC_ASSERT_NEVER(a_month_range, v6_q && (date_q.month_index > 4'd11), "month out of range")
  `ESC_ASSERT_NEVER(a_mday_range,
                    v6_q && ((date_q.day_of_month == 5'd0) || (date_q.day_of_month > 5'd31)),
                    "day of month out of range")
  `ESC_ASSERT_NEVER(a_wday_range, v6_q && (date_q.weekday > 3'd6), "weekday out of range")
  `ESC_ASSERT(a_walk_done, v5_q |-> ($past(yd4_q.days) < 11'd366),
              "year walk left more than a year")

endmodule

FILE: design/epoch_seconds_to_calendar.sv
// Top level: epoch seconds plus time zone offset to broken-down calendar fields.
`timescale 1ns / 1ps
`include "epoch_seconds_to_calendar_macros.svh"
// Usage
//   Input: drive epoch_seconds_i and raise start_i; the word is taken at each rising
//   edge with start_i high. busy_o stays low, so a new word may enter every cycle.
//   Config: cfg_data_i (signed seconds) is written when cfg_valid_i is high;
//   cfg_ready_o is always high. Write it only while no conversion is in flight.
//   Output: done_o is high for one cycle with all calendar fields valid beside it;
//   the receiver must take the word in that cycle, there is no back-pressure.
// Timing
//   Throughput is one word per cycle. The depth is set by the offset add, three
//   reciprocal multiply and correct pairs (/60, /60, /24), the four-year block
//   division, two stages of year walking and two of month lookup.
// Reset
//   rst_ni clears all valid bits and sets the offset to zero (UTC); words in flight
//   are dropped.
module epoch_seconds_to_calendar
  import esc_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [EpochW-1:0]         epoch_seconds_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic signed [OffsetW-1:0] cfg_data_i,
  output logic                      done_o,
  output logic [5:0]                second_o,
  output logic [5:0]                minute_o,
  output logic [4:0]                hour_o,
  output logic [2:0]                weekday_o,
  output logic [7:0]                years_since_1900_o,
  output logic [8:0]                day_of_year_o,
  output logic [3:0]                month_index_o,
  output logic [4:0]                day_of_month_o
);

  logic               accept;
  logic [OffsetW-1:0] off_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      off_q <= cfg_data_i;
    end
  end

  // Stage 1: offset add, wrapping
  logic              v1_q;
  logic [EpochW-1:0] t_q;

  // Stage 2: seconds product
  logic        v2_q;
  logic [60:0] pa_q;
  logic [4:0]  xa_q;
  logic [1:0]  ta_q;

  // Stage 3: correct, split off seconds
  logic        v3_q;
  logic [26:0] m_q;
  logic [5:0]  sec3_q;
  logic [26:0] qa0, m_d;
  logic [4:0]  ra;

  always_comb begin
    qa0 = pa_q[Shift15 +: 27];
    ra  = 5'(xa_q - 5'(qa0[4:0] * 5'd15));
    m_d = qa0;
    if (ra >= 5'd15) begin
      m_d = qa0 + 27'd1;
      ra  = ra - 5'd15;
    end
  end

  // Stage 4: minutes product
  logic        v4_q;
  logic [55:0] pb_q;
  logic [4:0]  xb_q;
  logic [1:0]  tb_q;
  logic [5:0]  sec4_q;

  // Stage 5: correct, split off minutes
  logic        v5_q;
  logic [20:0] h_q;
  logic [5:0]  sec5_q, min5_q;
  logic [20:0] qb0, h_d;
  logic [4:0]  rb;

  always_comb begin
    qb0 = pb_q[Shift15 +: 21];
    rb  = 5'(xb_q - 5'(qb0[4:0] * 5'd15));
    h_d = qb0;
    if (rb >= 5'd15) begin
      h_d = qb0 + 21'd1;
      rb  = rb - 5'd15;
    end
  end

  // Stage 6: hours product (divide by 8, then by 3)
  logic        v6_q;
  logic [36:0] pc_q;
  logic [2:0]  xc_q;
  logic [2:0]  tc_q;
  logic [5:0]  sec6_q, min6_q;

  // Stage 7: correct, split off hours, whole days remain
  logic             v7_q;
  logic [DaysW-1:0] days_q;
  esc_hms_t         hms7_q;
  logic [DaysW-1:0] qc0, days_d;
  logic [2:0]       rc;

  always_comb begin
    qc0    = pc_q[Shift3 +: DaysW];
    rc     = 3'(xc_q - 3'(qc0[2:0] * 3'd3));
    days_d = qc0;
    if (rc >= 3'd3) begin
      days_d = qc0 + 16'd1;
      rc     = rc - 3'd3;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q         <= epoch_seconds_i + {{(EpochW-OffsetW){off_q[OffsetW-1]}}, off_q};
    pa_q        <= 61'(t_q[31:2]) * 61'(Recip15);
    xa_q        <= t_q[6:2];
    ta_q        <= t_q[1:0];
    m_q         <= m_d;
    sec3_q      <= {ra[3:0], ta_q};
    pb_q        <= 56'(m_q[26:2]) * 56'(Recip15);
    xb_q        <= m_q[6:2];
    tb_q        <= m_q[1:0];
    sec4_q      <= sec3_q;
    h_q         <= h_d;
    sec5_q      <= sec4_q;
    min5_q      <= {rb[3:0], tb_q};
    pc_q        <= 37'(h_q[20:3]) * 37'(Recip3);
    xc_q        <= h_q[5:3];
    tc_q        <= h_q[2:0];
    sec6_q      <= sec5_q;
    min6_q      <= min5_q;
    days_q      <= days_d;
    hms7_q      <= '{second: sec6_q, minute: min6_q, hour: {rc[1:0], tc_q}};
  end

  // Date back end; time of day rides alongside in a matching delay line
  logic      date_v;
  esc_date_t date;
  esc_hms_t  hms_dly_q [DateLat];

  esc_date u_date (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v7_q),
    .days_i  (days_q),
    .valid_o (date_v),
    .date_o  (date)
  );

  always_ff @(posedge clk_i) begin
    hms_dly_q[0] <= hms7_q;
    for (int i = 1; i < DateLat; i++) begin
      hms_dly_q[i] <= hms_dly_q[i-1];
    end
  end

  assign done_o             = date_v;
  assign second_o           = hms_dly_q[DateLat-1].second;
  assign minute_o           = hms_dly_q[DateLat-1].minute;
  assign hour_o             = hms_dly_q[DateLat-1].hour;
  assign weekday_o          = date.weekday;
  assign years_since_1900_o = date.years_since_1900;
  assign day_of_year_o      = date.day_of_year;
  assign month_index_o      = date.month_index;
  assign day_of_month_o     = date.day_of_month;

  `ESC_ASSERT(a_latency, done_o |-> $past(accept, 13), "result without a matching word")
  `ESC_ASSERT_NEVER(a_sec_min_range, done_o && ((second_o > 6'd59) || (minute_o > 6'd59)),
                    "second or minute out of range")
  `ESC_ASSERT_NEVER(a_hour_range, done_o && (hour_o > 5'd23), "hour out of range")

endmodule
